// File: sv/wav_hdr_pkg.sv
package wav_hdr_pkg;

	localparam int BYTE_W = 8;
	localparam int OUT_W  = 8;

	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam logic [31:0] RATE_44K1   = 32'd44100;
	localparam logic [31:0] RATE_48K    = 32'd48000;
	localparam logic [31:0] FMT_MIN_LEN = 32'd16;

	typedef enum logic [1:0] {
		ST_PARSING = 2'd0,
		ST_DONE    = 2'd1,
		ST_ERROR   = 2'd2
	} status_t;

	typedef enum logic [10:0] {
		PH_RIFF_TAG   = 11'b000_0000_0001,
		PH_RIFF_SIZE  = 11'b000_0000_0010,
		PH_WAVE_TAG   = 11'b000_0000_0100,
		PH_CHUNK_TAG  = 11'b000_0000_1000,
		PH_CHUNK_SIZE = 11'b000_0001_0000,
		PH_FMT_TAG    = 11'b000_0010_0000,
		PH_CHANNELS   = 11'b000_0100_0000,
		PH_RATE       = 11'b000_1000_0000,
		PH_SKIP_SIX   = 11'b001_0000_0000,
		PH_BITS       = 11'b010_0000_0000,
		PH_SKIP       = 11'b100_0000_0000
	} phase_t;

endpackage

// File: sv/wav_header_parser_top.sv
// RIFF/WAVE PCM header parser. Feed the file one byte per word on the slave
// stream; tuser bit 0 set on a word restarts the parse with that byte as
// file offset 0. Every accepted byte yields one result word on the master
// stream, holding the status (parsing, done, sticky error) and the channel
// count, rate and sample size checked so far. One byte is taken every cycle
// while the skid is empty: the whole parse step for a byte is a combinational
// next-state update of the header registers. Results pass through an output
// register backed by one skid entry, so the input keeps flowing when the
// master side first stalls, and tready drops only while the skid is full.
module wav_header_parser_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [wav_hdr_pkg::BYTE_W-1:0]   s_axis_tdata,  // [7:0] byte_value
	input  logic                             s_axis_tuser,  // [0] restart
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [1:0] status, [3:2] channels, [4] rate_is_48k, [5] eight_bit_samples, [7:6] zero
	output logic [wav_hdr_pkg::OUT_W-1:0]    m_axis_tdata
);
	import wav_hdr_pkg::*;

	phase_t      phase_q;
	logic [2:0]  idx_q;
	logic [31:0] tag_q;
	logic [31:0] val_q;
	logic [31:0] skip_q;
	logic        have_fmt_q;
	logic [1:0]  chan_q;
	logic        rate_q;
	logic        eight_q;
	status_t     status_q;

	phase_t      phase_n;
	logic [2:0]  idx_n;
	logic [31:0] tag_n;
	logic [31:0] val_n;
	logic [31:0] skip_n;
	logic        have_fmt_n;
	logic [1:0]  chan_n;
	logic        rate_n;
	logic        eight_n;
	status_t     status_n;

	logic               in_acc;
	logic [OUT_W-1:0]   res;
	logic [OUT_W-1:0]   out_q;
	logic               out_vld_q;
	logic [OUT_W-1:0]   skid_q;
	logic               skid_vld_q;
	logic               out_pop;

	assign s_axis_tready = !skid_vld_q;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_pop       = out_vld_q && m_axis_tready;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_q;

	always_comb begin
		phase_t      ph;
		logic [2:0]  idx;
		logic [31:0] tag;
		logic [31:0] val;
		logic [31:0] skip;
		logic        hf;
		logic [1:0]  ch;
		logic        rt;
		logic        eb;
		status_t     st;
		logic [2:0]  idx_inc;
		logic [31:0] tag_new;
		logic [31:0] val_new;
		logic [31:0] byte_ext;

		if (s_axis_tuser) begin
			ph   = PH_RIFF_TAG;
			idx  = 3'd0;
			tag  = 32'd0;
			val  = 32'd0;
			skip = 32'd0;
			hf   = 1'b0;
			ch   = 2'd0;
			rt   = 1'b0;
			eb   = 1'b0;
			st   = ST_PARSING;
		end else begin
			ph   = phase_q;
			idx  = idx_q;
			tag  = tag_q;
			val  = val_q;
			skip = skip_q;
			hf   = have_fmt_q;
			ch   = chan_q;
			rt   = rate_q;
			eb   = eight_q;
			st   = status_q;
		end

		idx_inc  = idx + 3'd1;
		tag_new  = {tag[23:0], s_axis_tdata};
		byte_ext = {24'd0, s_axis_tdata};
		val_new  = ((idx == 3'd0) ? 32'd0 : val) | (byte_ext << {idx[1:0], 3'b000});

		phase_n    = ph;
		idx_n      = idx;
		tag_n      = tag;
		val_n      = val;
		skip_n     = skip;
		have_fmt_n = hf;
		chan_n     = ch;
		rate_n     = rt;
		eight_n    = eb;
		status_n   = st;

		if (st == ST_PARSING) begin
			case (ph)
				PH_RIFF_TAG, PH_WAVE_TAG, PH_CHUNK_TAG: begin
					tag_n = tag_new;
					idx_n = (idx_inc < 3'd4) ? idx_inc : 3'd0;
					if (idx_inc >= 3'd4) begin
						if (ph == PH_CHUNK_TAG) begin
							phase_n = PH_CHUNK_SIZE;
						end else if (ph == PH_RIFF_TAG) begin
							if (tag_new != TAG_RIFF) status_n = ST_ERROR;
							else phase_n = PH_RIFF_SIZE;
						end else begin
							if (tag_new != TAG_WAVE) status_n = ST_ERROR;
							else phase_n = PH_CHUNK_TAG;
						end
					end
				end
				PH_RIFF_SIZE: begin
					val_n = val_new;
					idx_n = (idx_inc < 3'd4) ? idx_inc : 3'd0;
					if (idx_inc >= 3'd4) phase_n = PH_WAVE_TAG;
				end
				PH_CHUNK_SIZE: begin
					val_n = val_new;
					idx_n = (idx_inc < 3'd4) ? idx_inc : 3'd0;
					if (idx_inc >= 3'd4) begin
						if (tag == TAG_FMT) begin
							if (val_new < FMT_MIN_LEN) begin
								status_n = ST_ERROR;
							end else begin
								skip_n  = val_new - FMT_MIN_LEN;
								phase_n = PH_FMT_TAG;
							end
						end else if (tag == TAG_DATA) begin
							status_n = hf ? ST_DONE : ST_ERROR;
						end else begin
							skip_n  = val_new;
							phase_n = (val_new != 32'd0) ? PH_SKIP : PH_CHUNK_TAG;
						end
					end
				end
				PH_FMT_TAG: begin
					val_n = val_new;
					idx_n = (idx_inc < 3'd2) ? idx_inc : 3'd0;
					if (idx_inc >= 3'd2) begin
						if (val_new != 32'd1) status_n = ST_ERROR;
						else phase_n = PH_CHANNELS;
					end
				end
				PH_CHANNELS: begin
					val_n = val_new;
					idx_n = (idx_inc < 3'd2) ? idx_inc : 3'd0;
					if (idx_inc >= 3'd2) begin
						if (val_new inside {32'd1, 32'd2}) begin
							chan_n  = val_new[1:0];
							phase_n = PH_RATE;
						end else begin
							status_n = ST_ERROR;
						end
					end
				end
				PH_RATE: begin
					val_n = val_new;
					idx_n = (idx_inc < 3'd4) ? idx_inc : 3'd0;
					if (idx_inc >= 3'd4) begin
						if (val_new == RATE_44K1) begin
							rate_n  = 1'b0;
							phase_n = PH_SKIP_SIX;
						end else if (val_new == RATE_48K) begin
							rate_n  = 1'b1;
							phase_n = PH_SKIP_SIX;
						end else begin
							status_n = ST_ERROR;
						end
					end
				end
				PH_SKIP_SIX: begin
					idx_n = (idx_inc < 3'd6) ? idx_inc : 3'd0;
					if (idx_inc >= 3'd6) phase_n = PH_BITS;
				end
				PH_BITS: begin
					val_n = val_new;
					idx_n = (idx_inc < 3'd2) ? idx_inc : 3'd0;
					if (idx_inc >= 3'd2) begin
						if (val_new inside {32'd8, 32'd16}) begin
							eight_n    = (val_new == 32'd8);
							have_fmt_n = 1'b1;
							phase_n    = (skip != 32'd0) ? PH_SKIP : PH_CHUNK_TAG;
						end else begin
							status_n = ST_ERROR;
						end
					end
				end
				PH_SKIP: begin
					skip_n = skip - 32'd1;
					if (skip == 32'd1) phase_n = PH_CHUNK_TAG;
				end
				default: begin
					status_n = ST_ERROR;
				end
			endcase
		end
	end

	assign res = {2'b00, eight_n, rate_n, chan_n, status_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_RIFF_TAG;
			idx_q      <= 3'd0;
			tag_q      <= 32'd0;
			val_q      <= 32'd0;
			skip_q     <= 32'd0;
			have_fmt_q <= 1'b0;
			chan_q     <= 2'd0;
			rate_q     <= 1'b0;
			eight_q    <= 1'b0;
			status_q   <= ST_PARSING;
		end else if (in_acc) begin
			phase_q    <= phase_n;
			idx_q      <= idx_n;
			tag_q      <= tag_n;
			val_q      <= val_n;
			skip_q     <= skip_n;
			have_fmt_q <= have_fmt_n;
			chan_q     <= chan_n;
			rate_q     <= rate_n;
			eight_q    <= eight_n;
			status_q   <= status_n;
		end
	end

	// output register plus one skid entry; skid only fills while output is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_pop) begin
			if (skid_vld_q) begin
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= in_acc;
			end
		end else if (in_acc) begin
			if (out_vld_q) skid_vld_q <= 1'b1;
			else out_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_pop) begin
			if (skid_vld_q) out_q <= skid_q;
			else if (in_acc) out_q <= res;
		end else if (in_acc) begin
			if (out_vld_q) skid_q <= res;
			else out_q <= res;
		end
	end

endmodule

// File: sv/wav_hdr_checker.sv
module wav_hdr_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [wav_hdr_pkg::OUT_W-1:0]   m_axis_tdata
);
	import wav_hdr_pkg::*;

	// a held result word stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// a result only appears after an accepted byte
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
		else $error("result word without accepted byte");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[1:0] != 2'b11)
		else $error("bad status code");

	// done means a full fmt chunk was seen, so channels is known
	a_done_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] == ST_DONE |->
			m_axis_tdata[3:2] == 2'd1 || m_axis_tdata[3:2] == 2'd2)
		else $error("done without valid channel count");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[7:6] == 2'b00)
		else $error("pad bits set");

endmodule

bind wav_header_parser_top wav_hdr_checker u_wav_hdr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
